>>> src/allpass_cascade_smear_defines.svh
// Assertion macros for the allpass cascade.
// Used by allpass_cascade_smear.sv; expects signals named clock and reset in scope.
`ifndef ALLPASS_CASCADE_SMEAR_DEFINES_SVH
`define ALLPASS_CASCADE_SMEAR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/acs_pkg.sv
// Shared constants and types for the allpass cascade.
// No dependencies; imported by allpass_cascade_smear.
package acs_pkg;

   localparam int MEM_BITS          = 32;
   localparam int COEF_BITS         = 16;
   localparam int COEF_FRAC         = 15;
   localparam int PROD_BITS         = MEM_BITS + COEF_BITS;
   localparam int SUM_BITS          = MEM_BITS + 2;
   localparam int DEF_NUM_SECTIONS  = 96;
   localparam int DEF_SAMPLE_BITS   = 24;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_Z,
      S_ADD_X,
      S_MUL_X,
      S_ADD_Y,
      S_OUT
   } state_type;

   typedef struct packed {
      logic mul_sel_x;
      logic add_sel_x;
      logic mem_we;
   } ctrl_type;

endpackage

>>> src/allpass_cascade_smear.sv
// Each sample passes through the sections in turn; req_stall holds off a new sample until
// the last result is loaded into the output register. Each section steps through MUL_Z,
// ADD_X, MUL_X and ADD_Y on the one shared multiplier and one shared saturating adder.
// Reset (synchronous, active high) clears the coefficient to zero and marks all section
// states empty through per-section valid bits, so they read as zero; no clearing pass.
module allpass_cascade_smear
   import acs_pkg::*;
#(
   parameter int NUM_SECTIONS = DEF_NUM_SECTIONS,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic signed [COEF_BITS-1:0]   csr_coefficient,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

`include "allpass_cascade_smear_defines.svh"

   localparam int IDX_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SECTIONS - 1);
   localparam logic signed [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1 << (COEF_FRAC - 1));
   localparam logic signed [SUM_BITS-1:0] MEM_HI = SUM_BITS'((64'sd1 <<< (MEM_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] MEM_LO = -MEM_HI - SUM_BITS'(1);
   localparam logic signed [MEM_BITS-1:0] OUT_HI =
      MEM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [MEM_BITS-1:0] OUT_LO = -OUT_HI - MEM_BITS'(1);

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic signed [COEF_BITS-1:0]   coef_ff;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic signed [MEM_BITS-1:0]    v_ff, v_in;
   logic signed [MEM_BITS-1:0]    z_ff;
   logic signed [MEM_BITS-1:0]    x_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [MEM_BITS-1:0]    rd_data_ff;
   logic                          rd_valid_ff;
   logic [NUM_SECTIONS-1:0]       sec_valid_ff;
   logic signed [MEM_BITS-1:0]    mem [NUM_SECTIONS];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out_ff, rsp_sample_out_in;

   logic                          last_sec;
   logic                          out_free;
   logic signed [MEM_BITS-1:0]    z_cur;
   logic signed [MEM_BITS-1:0]    mul_a;
   logic signed [PROD_BITS:0]     rnd_sum;
   logic signed [SUM_BITS-1:0]    rnd_val;
   logic signed [SUM_BITS-1:0]    add_a, add_b, add_sum;
   logic signed [MEM_BITS-1:0]    add_sat;
   logic signed [MEM_BITS-1:0]    out_sat;

   assign last_sec  = (idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_MUL_Z;
         S_MUL_Z: state_in = S_ADD_X;
         S_ADD_X: state_in = S_MUL_X;
         S_MUL_X: state_in = S_ADD_Y;
         S_ADD_Y: state_in = last_sec ? S_OUT : S_MUL_Z;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         S_ADD_X: begin
            ctrl.add_sel_x = 1'b1;
            ctrl.mem_we    = 1'b1;
         end
         S_MUL_X: ctrl.mul_sel_x = 1'b1;
         default: ctrl = '0;
      endcase
   end

   // Shared multiplier: z*g for the feedforward term, then g*x for the output term.
   assign z_cur   = rd_valid_ff ? rd_data_ff : '0;
   assign mul_a   = ctrl.mul_sel_x ? x_ff : z_cur;
   assign prod_in = PROD_BITS'(mul_a * coef_ff);

   // Round to nearest with ties upward, then one saturating add or subtract.
   assign rnd_sum = (PROD_BITS + 1)'(prod_ff) + ROUND_HALF;
   assign rnd_val = SUM_BITS'(rnd_sum >>> COEF_FRAC);
   assign add_a   = ctrl.add_sel_x ? SUM_BITS'(v_ff) : SUM_BITS'(z_ff);
   assign add_b   = ctrl.add_sel_x ? rnd_val : -rnd_val;
   assign add_sum = add_a + add_b;

   always_comb begin
      if (add_sum > MEM_HI) begin
         add_sat = MEM_HI[MEM_BITS-1:0];
      end else if (add_sum < MEM_LO) begin
         add_sat = MEM_LO[MEM_BITS-1:0];
      end else begin
         add_sat = add_sum[MEM_BITS-1:0];
      end
   end

   always_comb begin
      if (v_ff > OUT_HI) begin
         out_sat = OUT_HI;
      end else if (v_ff < OUT_LO) begin
         out_sat = OUT_LO;
      end else begin
         out_sat = v_ff;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      v_in   = v_ff;
      if (state_ff == S_IDLE) begin
         idx_in = '0;
         v_in   = MEM_BITS'(req_sample_in);
      end else if (state_ff == S_ADD_Y) begin
         v_in = add_sat;
         if (!last_sec) idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_sample_out_in = out_sat[SAMPLE_BITS-1:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         coef_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) coef_ff <= csr_coefficient;
         if (ctrl.mem_we) sec_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      v_ff              <= v_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rd_valid_ff       <= sec_valid_ff[idx_in];
      if (state_ff == S_MUL_Z || state_ff == S_MUL_X) prod_ff <= prod_in;
      if (state_ff == S_MUL_Z) z_ff <= z_cur;
      if (ctrl.add_sel_x) x_ff <= add_sat;
   end

   // Section state memory; the read address runs one step ahead of the sequencer.
   always_ff @(posedge clock) begin
      if (ctrl.mem_we) mem[idx_ff] <= add_sat;
      rd_data_ff <= mem[idx_in];
   end

   `ACS_ASSERT_NEXT(a_start_at_first, req_valid && !req_stall,
      state_ff == S_MUL_Z && idx_ff == '0, "sample did not start at the first section")
   `ACS_ASSERT_NEXT(a_state_marked, state_ff == S_ADD_X,
      sec_valid_ff[$past(idx_ff)], "section state written without its valid bit")
   `ACS_ASSERT_NEXT(a_last_to_out, state_ff == S_ADD_Y && last_sec,
      state_ff == S_OUT, "last section did not lead to the output step")
   `ACS_ASSERT_NEXT(a_out_loaded, state_ff == S_OUT && out_free,
      rsp_valid_ff && state_ff == S_IDLE, "finished result not presented")

endmodule

>>> tb/allpass_cascade_smear_tb.sv
// Self-checking testbench for allpass_cascade_smear: directed and random samples across
// several coefficient settings, checked against a bit-exact cascade model. Uses acs_pkg.
module allpass_cascade_smear_tb;
   import acs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS = DEF_NUM_SECTIONS;
   localparam int SW = DEF_SAMPLE_BITS;
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MAX = 16'sh7fff;
   localparam logic signed [COEF_BITS-1:0] COEF_MIN = 16'sh8000;
   localparam int ITEMS_PER_PHASE = 96;

   // Tracks the cascade state, predicts each output and checks what comes back.
   class cascade_tracker;
      longint section_state[NS];
      longint g_value;
      logic signed [SW-1:0] pending_outputs[$];
      int errors;

      function new();
         foreach (section_state[i]) section_state[i] = 0;
         g_value = 0;
         errors = 0;
      endfunction

      function longint clip(longint v, int bits);
         longint hi;
         longint lo;
         hi = (64'sd1 <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // Scale by 2^-15, rounding to nearest with ties upward.
      function longint rescale(longint p);
         return (p + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      endfunction

      function void set_coefficient(logic signed [COEF_BITS-1:0] c);
         g_value = c;
      endfunction

      function void note_sample(logic signed [SW-1:0] s);
         longint v;
         longint z;
         longint x;
         logic signed [SW-1:0] y;
         v = s;
         for (int i = 0; i < NS; i++) begin
            z = section_state[i];
            x = clip(v + rescale(z * g_value), MEM_BITS);
            v = clip(z - rescale(g_value * x), MEM_BITS);
            section_state[i] = x;
         end
         y = SW'(clip(v, SW));
         pending_outputs.push_back(y);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_sample(logic signed [SW-1:0] got);
         logic signed [SW-1:0] want;
         if (pending_outputs.size() == 0) begin
            report($sformatf("unexpected output %0d", got));
         end else begin
            want = pending_outputs.pop_front();
            if (got !== want)
               report($sformatf("sample_out got %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic signed [COEF_BITS-1:0] csr_coefficient = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SW-1:0] rsp_sample_out;

   cascade_tracker tracker = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_window = 0;
   logic signed [SW-1:0] last_sample = '0;

   allpass_cascade_smear u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_coefficient(csr_coefficient),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

   always #1 clock = ~clock;

   // The receiver picks a new stall behavior every window of cycles.
   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_window = $urandom_range(64, 512);
      end else begin
         stall_window--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= (stall_window % 5) < 3;
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_sample(rsp_sample_out);
   end

   task automatic send_sample(input logic signed [SW-1:0] s);
      req_sample_in <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_sample(s);
      last_sample = s;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(100, 500)) @(posedge clock);
         else
            repeat ($urandom_range(1, 8)) @(posedge clock);
         // Occasionally a long burst gives a stretch with no sender gaps.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 7);
      end
   endtask

   // Holds the sender off until every expected output has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_coefficient(input logic signed [COEF_BITS-1:0] c);
      wait_idle();
      csr_coefficient <= c;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.set_coefficient(c);
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return SW'($urandom);
         5: return SAMPLE_MAX;
         6: return SAMPLE_MIN;
         7, 8: return SW'($signed($urandom_range(0, 511)) - 256);
         default: return last_sample;
      endcase
   endfunction

   initial begin
      logic signed [COEF_BITS-1:0] phase_coef[6];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Coefficient at its reset value: the cascade is a pure delay line.
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(SW'(1));
      send_sample(SW'(-1));

      // Coefficient near +1: impulse, saturating runs and alternating bit patterns.
      write_coefficient(COEF_MAX);
      send_sample(SAMPLE_MAX);
      repeat (3) send_sample('0);
      repeat (4) send_sample(SAMPLE_MAX);
      repeat (4) send_sample(SAMPLE_MIN);
      send_sample(24'sh555555);
      send_sample(24'shaaaaaa);

      // Coefficient of exactly -1.0 is accepted and must stay bounded.
      write_coefficient(COEF_MIN);
      repeat (3) send_sample(SAMPLE_MAX);
      repeat (3) send_sample(SAMPLE_MIN);

      phase_coef[0] = COEF_MAX;
      phase_coef[1] = COEF_MIN;
      phase_coef[2] = -COEF_MAX;
      phase_coef[3] = COEF_BITS'($urandom);
      phase_coef[4] = COEF_BITS'($urandom);
      phase_coef[5] = COEF_BITS'($signed($urandom_range(0, 2047)) - 1024);
      foreach (phase_coef[p]) begin
         write_coefficient(phase_coef[p]);
         repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
      end

      wait_idle();
      repeat (4 * NS + 16) @(posedge clock);
      if (tracker.pending_outputs.size() != 0)
         tracker.report($sformatf("%0d outputs never arrived",
                                  tracker.pending_outputs.size()));
      if (tracker.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout at %0t", $realtime);
      $display("Regression FAIL");
      $finish;
   end

endmodule
